FILE: rtl/dsg_pkg.sv
// Shared types, constants and table functions of the decaying signal grid.
package dsg_pkg;

  localparam int unsigned STRENGTH_W = 16;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned DEN_W      = 32;
  localparam int unsigned WEIGHT_W   = 19;
  localparam int unsigned PROD_W     = 35;

  localparam logic [STRENGTH_W-1:0] Q16_MAX = 16'hFFFF;
  localparam logic [STRENGTH_W-1:0] EPSILON = 16'd6;

  // Q0.32 factors 2^-(2^k/256), k = 0..7 (entry k sits at [k]).
  localparam logic [7:0][31:0] HALF_STEPS = {
    32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874793,
    32'd4202935003, 32'd4248701966, 32'd4271771998, 32'd4283353946
  };

  typedef enum logic [1:0] {
    CMD_OBSERVE  = 2'd0,
    CMD_QUERY    = 2'd1,
    CMD_DECAY    = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X  = 2'd0,
    CFG_ORIGIN_Y  = 2'd1,
    CFG_HALF_LIFE = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic clr_step;
    logic obs_rd;
    logic obs_mul;
    logic obs_wr;
    logic q_init;
    logic q_addr;
    logic q_mul;
    logic q_acc;
    logic q_adv;
    logic div_start_q;
    logic q_done;
    logic dec_rd;
    logic dec_zero;
    logic div_start_d;
    logic dec_mul;
    logic dec_wr;
    logic slot_next;
    logic out_load;
  } dsg_cmd_t;

  typedef struct packed {
    cmd_e command;
    logic reject;
    logic hl_zero;
    logic cell_in;
    logic q_last;
    logic slot_last;
    logic small_s;
    logic fresh;
    logic div_done;
    logic out_free;
  } dsg_status_t;

  // Weight of a cell at manhattan distance d: 360360 / (1 + d).
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [3:0] d);
    logic [WEIGHT_W-1:0] w;
    unique case (d)
      4'd0:    w = 19'd360360;
      4'd1:    w = 19'd180180;
      4'd2:    w = 19'd120120;
      4'd3:    w = 19'd90090;
      4'd4:    w = 19'd72072;
      4'd5:    w = 19'd60060;
      4'd6:    w = 19'd51480;
      4'd7:    w = 19'd45045;
      4'd8:    w = 19'd40040;
      4'd9:    w = 19'd36036;
      4'd10:   w = 19'd32760;
      4'd11:   w = 19'd30030;
      4'd12:   w = 19'd27720;
      4'd13:   w = 19'd25740;
      4'd14:   w = 19'd24024;
      default: w = 19'd22522;
    endcase
    return w;
  endfunction

  // Q1.16 fraction 2^-(idx/256); used with constant arguments to fill a table.
  function automatic logic [16:0] frac_q16(input logic [7:0] idx);
    logic [63:0] acc;
    acc = 64'h1_0000_0000;
    for (int k = 0; k < 8; k++) begin
      if (idx[k]) begin
        acc = (acc * {32'd0, HALF_STEPS[k]} + 64'h8000_0000) >> 32;
      end
    end
    acc = (acc + 64'd32768) >> 16;
    return acc[16:0];
  endfunction

endpackage

FILE: rtl/dsg_if.sv
// Channel interfaces: item input, result output and register write.
interface dsg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [2:0]         kind;
  logic [15:0]        strength;
  logic [31:0]        tick;
  logic [1:0]         radius;
  modport source (output valid, command, pos_x, pos_y, kind, strength, tick, radius,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, kind, strength, tick, radius,
                output ready);
endinterface

interface dsg_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] value;
  modport source (output valid, status, value, input ready);
  modport sink (input valid, status, value, output ready);
endinterface

interface dsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/dsg_ram.sv
// Generic single-port RAM with registered read.
module dsg_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              we_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dsg_div.sv
// Restoring divider, one quotient bit per cycle.
module dsg_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= cnt_q == CNT_W'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (cnt_q != '0) begin
      quot_q <= {quot_q[NUM_W-2:0], fits};
      rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/dsg_ctrl.sv
// Sequencer: clearing pass, observe, query walk and decay sweep.
module dsg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dsg_pkg::dsg_status_t  status_i,
  output dsg_pkg::dsg_cmd_t     cmd_o
);
  import dsg_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE,
    ST_OBS_RD, ST_OBS_MUL, ST_OBS_WR,
    ST_Q_ADDR, ST_Q_MUL, ST_Q_ACC, ST_Q_DIVS, ST_Q_DIV,
    ST_DEC_RD, ST_DEC_CHK, ST_DEC_DIV, ST_DEC_MUL, ST_DEC_WR,
    ST_RESP
  } state_e;

  state_e   state_q, state_d;
  dsg_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status_i.slot_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (status_i.reject) begin
          state_d = ST_RESP;
        end else begin
          unique case (status_i.command)
            CMD_OBSERVE: state_d = ST_OBS_RD;
            CMD_QUERY: begin
              cmd.q_init = 1'b1;
              state_d    = ST_Q_ADDR;
            end
            CMD_DECAY:    state_d = status_i.hl_zero ? ST_RESP : ST_DEC_RD;
            CMD_RESERVED: state_d = ST_RESP;
          endcase
        end
      end
      ST_OBS_RD: begin
        cmd.obs_rd = 1'b1;
        state_d    = ST_OBS_MUL;
      end
      ST_OBS_MUL: begin
        cmd.obs_mul = 1'b1;
        state_d     = ST_OBS_WR;
      end
      ST_OBS_WR: begin
        cmd.obs_wr = 1'b1;
        state_d    = ST_RESP;
      end
      ST_Q_ADDR: begin
        cmd.q_addr = 1'b1;
        if (status_i.cell_in) begin
          state_d = ST_Q_MUL;
        end else if (status_i.q_last) begin
          state_d = ST_Q_DIVS;
        end else begin
          cmd.q_adv = 1'b1;
        end
      end
      ST_Q_MUL: begin
        cmd.q_mul = 1'b1;
        state_d   = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        cmd.q_acc = 1'b1;
        if (status_i.q_last) begin
          state_d = ST_Q_DIVS;
        end else begin
          cmd.q_adv = 1'b1;
          state_d   = ST_Q_ADDR;
        end
      end
      ST_Q_DIVS: begin
        cmd.div_start_q = 1'b1;
        state_d         = ST_Q_DIV;
      end
      ST_Q_DIV: begin
        if (status_i.div_done) begin
          cmd.q_done = 1'b1;
          state_d    = ST_RESP;
        end
      end
      ST_DEC_RD: begin
        cmd.dec_rd = 1'b1;
        state_d    = ST_DEC_CHK;
      end
      ST_DEC_CHK: begin
        if (status_i.small_s || status_i.fresh) begin
          cmd.dec_zero  = status_i.small_s;
          cmd.slot_next = 1'b1;
          state_d       = status_i.slot_last ? ST_RESP : ST_DEC_RD;
        end else begin
          cmd.div_start_d = 1'b1;
          state_d         = ST_DEC_DIV;
        end
      end
      ST_DEC_DIV: begin
        if (status_i.div_done) state_d = ST_DEC_MUL;
      end
      ST_DEC_MUL: begin
        cmd.dec_mul = 1'b1;
        state_d     = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        cmd.dec_wr    = 1'b1;
        cmd.slot_next = 1'b1;
        state_d       = status_i.slot_last ? ST_RESP : ST_DEC_RD;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_ready_o = state_q == ST_IDLE;

endmodule

FILE: rtl/dsg_dp.sv
// Datapath: item and register storage, stores, arithmetic and result register.
module dsg_dp #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64,
  parameter int KINDS       = 6,
  parameter int CELL_SHIFT  = 4,
  parameter int MAX_RADIUS  = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dsg_pkg::dsg_cmd_t    cmd_i,
  output dsg_pkg::dsg_status_t status_o,
  input  logic [1:0]           command_i,
  input  logic signed [15:0]   pos_x_i,
  input  logic signed [15:0]   pos_y_i,
  input  logic [2:0]           kind_i,
  input  logic [15:0]          strength_i,
  input  logic [31:0]          tick_i,
  input  logic [1:0]           radius_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 out_status_o,
  output logic [15:0]          out_value_o
);
  import dsg_pkg::*;

  localparam int SLOTS  = GRID_WIDTH * GRID_HEIGHT * KINDS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CX_W   = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int CY_W   = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int NBX_W  = CX_W + 5;
  localparam int NBY_W  = CY_W + 5;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [CY_W-1:0] y,
                                                input logic [CX_W-1:0] x,
                                                input logic [2:0] k);
    int idx;
    idx = (int'(y) * GRID_WIDTH + int'(x)) * KINDS + int'(k);
    return SLOT_W'(idx);
  endfunction

  // Item and configuration registers
  cmd_e               cmd_q;
  logic signed [15:0] pos_x_q, pos_y_q;
  logic [2:0]         kind_q;
  logic [15:0]        str_q;
  logic [31:0]        tick_q;
  logic [1:0]         rad_q;
  logic signed [15:0] origin_x_q, origin_y_q;
  logic [31:0]        half_life_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cmd_e'(command_i);
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      kind_q  <= kind_i;
      str_q   <= strength_i;
      tick_q  <= tick_i;
      rad_q   <= radius_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      half_life_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ORIGIN_X:  origin_x_q  <= cfg_data_i[15:0];
        CFG_ORIGIN_Y:  origin_y_q  <= cfg_data_i[15:0];
        CFG_HALF_LIFE: half_life_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cell location and rejection
  logic signed [16:0] off_x, off_y;
  logic [15:0]        ux, uy;
  logic               pos_bad, kind_bad, reject;

  assign off_x    = 17'(pos_x_q) - 17'(origin_x_q);
  assign off_y    = 17'(pos_y_q) - 17'(origin_y_q);
  assign ux       = off_x[15:0] >> CELL_SHIFT;
  assign uy       = off_y[15:0] >> CELL_SHIFT;
  assign pos_bad  = off_x[16] | off_y[16] | (ux >= 16'(GRID_WIDTH)) | (uy >= 16'(GRID_HEIGHT));
  assign kind_bad = {1'b0, kind_q} >= 4'(KINDS);
  assign reject   = (cmd_q == CMD_RESERVED) ||
                    ((cmd_q == CMD_OBSERVE || cmd_q == CMD_QUERY) && (pos_bad || kind_bad));

  // Neighbourhood walk
  logic [2:0]          r_eff;
  logic signed [3:0]   r_s, dx_q, dy_q;
  logic signed [NBX_W-1:0] nx;
  logic signed [NBY_W-1:0] ny;
  logic [3:0]          adx, ady, man_dist;
  logic                cell_in, q_last;
  logic [SLOT_W-1:0]   nb_slot, obs_slot;

  assign r_eff   = (3'(rad_q) > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : 3'(rad_q);
  assign r_s     = signed'({1'b0, r_eff});
  assign q_last  = (dx_q == r_s) && (dy_q == r_s);
  assign nx      = $signed({5'd0, ux[CX_W-1:0]}) + NBX_W'(dx_q);
  assign ny      = $signed({5'd0, uy[CY_W-1:0]}) + NBY_W'(dy_q);
  assign cell_in = !nx[NBX_W-1] && (nx < NBX_W'(GRID_WIDTH)) &&
                   !ny[NBY_W-1] && (ny < NBY_W'(GRID_HEIGHT));
  assign adx      = dx_q[3] ? 4'(-dx_q) : 4'(dx_q);
  assign ady      = dy_q[3] ? 4'(-dy_q) : 4'(dy_q);
  assign man_dist = adx + ady;
  assign nb_slot  = slot_of(ny[CY_W-1:0], nx[CX_W-1:0], kind_q);
  assign obs_slot = slot_of(uy[CY_W-1:0], ux[CX_W-1:0], kind_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_init) begin
      dx_q <= -r_s;
      dy_q <= -r_s;
    end else if (cmd_i.q_adv) begin
      if (dx_q == r_s) begin
        dx_q <= -r_s;
        dy_q <= dy_q + 4'sd1;
      end else begin
        dx_q <= dx_q + 4'sd1;
      end
    end
  end

  // Slot counter for the clearing pass and the decay sweep
  logic [SLOT_W-1:0] slot_q;
  logic              slot_last;

  assign slot_last = slot_q == SLOT_W'(SLOTS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (cmd_i.clr_step || cmd_i.slot_next) begin
      slot_q <= slot_last ? '0 : slot_q + 1'b1;
    end
  end

  // Stores
  logic [SLOT_W-1:0] addr;
  logic              s_we, t_we, re;
  logic [15:0]       s_wdata, s_rdata;
  logic [31:0]       t_wdata, t_rdata;

  always_comb begin
    priority if (cmd_i.obs_rd || cmd_i.obs_wr) begin
      addr = obs_slot;
    end else if (cmd_i.q_addr) begin
      addr = nb_slot;
    end else begin
      addr = slot_q;
    end
  end

  dsg_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_strength (
    .clk_i, .addr_i(addr), .we_i(s_we), .wdata_i(s_wdata), .re_i(re), .rdata_o(s_rdata)
  );

  dsg_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_stamp (
    .clk_i, .addr_i(addr), .we_i(t_we), .wdata_i(t_wdata), .re_i(re), .rdata_o(t_rdata)
  );

  // Shared divider
  logic        div_start, div_done;
  logic [47:0] div_num, quot;
  logic [31:0] div_den;
  logic [31:0] el;
  logic [47:0] sum_q;
  logic [31:0] total_q;

  assign el        = tick_q - t_rdata;
  assign div_start = cmd_i.div_start_q | cmd_i.div_start_d;
  assign div_num   = cmd_i.div_start_q ? sum_q + 48'(total_q >> 1) : {8'd0, el, 8'd0};
  assign div_den   = cmd_i.div_start_q ? total_q : half_life_q;

  dsg_div #(.NUM_W(SUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(quot)
  );

  // Fraction table 2^-(i/256)
  logic [16:0] frac_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_frac
    assign frac_lut[g] = frac_q16(8'(g));
  end

  // Products
  logic [WEIGHT_W-1:0] w_q;
  logic [PROD_W-1:0]   prod_q;
  logic [15:0]         inv_s;
  logic [31:0]         obs_prod;
  logic [34:0]         q_prod;
  logic [32:0]         d_prod;

  assign inv_s    = Q16_MAX - s_rdata;
  assign obs_prod = 32'(inv_s) * 32'(str_q) + 32'd32767;
  assign q_prod   = 35'(s_rdata) * 35'(w_q);
  assign d_prod   = 33'(s_rdata) * 33'(frac_lut[quot[7:0]]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_addr) w_q <= weight_of(man_dist);
    priority if (cmd_i.obs_mul) prod_q <= PROD_W'(obs_prod);
    else if (cmd_i.q_mul)       prod_q <= q_prod;
    else if (cmd_i.dec_mul)     prod_q <= PROD_W'(d_prod);
    if (cmd_i.q_init) begin
      sum_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.q_acc) begin
      sum_q   <= sum_q + 48'(prod_q);
      total_q <= total_q + 32'(w_q);
    end
  end

  // Observe: add round((65535 - s) * in / 65535)
  logic [15:0] q0;
  logic [16:0] r0, qq, ns_w;
  logic [15:0] ns;

  assign q0   = prod_q[31:16];
  assign r0   = 17'(prod_q[15:0]) + 17'(q0);
  assign qq   = 17'(q0) + ((r0 >= 17'(Q16_MAX)) ? 17'd1 : 17'd0);
  assign ns_w = 17'(s_rdata) + qq;
  assign ns   = ns_w[16] ? Q16_MAX : ns_w[15:0];

  // Decay: scale by the fraction, then shift by whole half lives
  logic [32:0] t_rnd;
  logic [39:0] whole;
  logic [16:0] t_sh;
  logic [15:0] t_cl, dec_s;

  assign t_rnd = prod_q[32:0] + 33'd32768;
  assign whole = quot[47:8];
  assign t_sh  = (whole >= 40'd32) ? 17'd0 : (t_rnd[32:16] >> whole[4:0]);
  assign t_cl  = t_sh[16] ? Q16_MAX : t_sh[15:0];
  assign dec_s = (t_cl <= EPSILON) ? 16'd0 : t_cl;

  assign s_we    = cmd_i.clr_step | cmd_i.obs_wr | cmd_i.dec_zero | cmd_i.dec_wr;
  assign t_we    = cmd_i.clr_step | cmd_i.obs_wr | cmd_i.dec_wr;
  assign re      = cmd_i.obs_rd | (cmd_i.q_addr & cell_in) | cmd_i.dec_rd;
  assign s_wdata = cmd_i.obs_wr ? ns : (cmd_i.dec_wr ? dec_s : 16'd0);
  assign t_wdata = (cmd_i.obs_wr || cmd_i.dec_wr) ? tick_q : 32'd0;

  // Result and output register
  logic        res_status_q;
  logic [15:0] res_value_q;
  logic        out_valid_q, out_status_q;
  logic [15:0] out_value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      res_status_q <= reject;
      res_value_q  <= '0;
    end else if (cmd_i.q_done) begin
      res_value_q <= (quot[47:16] != '0) ? Q16_MAX : quot[15:0];
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;

  always_comb begin
    status_o           = '0;
    status_o.command   = cmd_q;
    status_o.reject    = reject;
    status_o.hl_zero   = half_life_q == '0;
    status_o.cell_in   = cell_in;
    status_o.q_last    = q_last;
    status_o.slot_last = slot_last;
    status_o.small_s   = s_rdata <= EPSILON;
    status_o.fresh     = tick_q <= t_rdata;
    status_o.div_done  = div_done;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

FILE: rtl/decaying_signal_grid.sv
// Top level of the decaying signal grid: sequencer, datapath and assertions.
//
//  channel | dir | beat carries                                   | handshake
//  --------+-----+------------------------------------------------+----------
//  in_i    | in  | command pos_x pos_y kind strength tick radius   | valid/ready
//  out_o   | out | status value                                   | valid/ready
//  cfg_i   | in  | index data (0 origin_x, 1 origin_y, 2 half life)| valid/ready
//
// One item at a time. Observe reads, updates and writes back one slot; query
// sums the weighted in-grid cells of the (2r+1)^2 square, then divides; decay
// sweeps every slot and divides only for a live one, on the bit-serial divider
// that the query shares.
// After reset a clearing pass writes every slot, GRID_WIDTH*GRID_HEIGHT*KINDS
// slots (24576 by default); no input beat is taken then, register writes are.
// A result beat waits in the output register while the next input beat is
// taken; a stalled output only holds the sequencer once the next result is due.
module decaying_signal_grid #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64,
  parameter int KINDS       = 6,
  parameter int CELL_SHIFT  = 4,
  parameter int MAX_RADIUS  = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsg_in_if.sink    in_i,
  dsg_out_if.source out_o,
  dsg_cfg_if.sink   cfg_i
);
  import dsg_pkg::*;

  dsg_cmd_t    cmd;
  dsg_status_t status;
  logic        in_fire;

  // Register writes are always taken; user sends them only when idle, unchecked.
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;

  dsg_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsg_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .KINDS       (KINDS),
    .CELL_SHIFT  (CELL_SHIFT),
    .MAX_RADIUS  (MAX_RADIUS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .status_o     (status),
    .command_i    (in_i.command),
    .pos_x_i      (in_i.pos_x),
    .pos_y_i      (in_i.pos_y),
    .kind_i       (in_i.kind),
    .strength_i   (in_i.strength),
    .tick_i       (in_i.tick),
    .radius_i     (in_i.radius),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_value_o  (out_o.value)
  );

  // Drop ready for at least the cycle after a beat is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input ready held after accepted beat");

  // A rejected item never carries a value.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |-> (out_o.value == 16'd0))
    else $error("rejected result with non-zero value");

  // A new result appears only out of a busy cycle.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result raised without work in progress");

  // The divider finishes only during a query or a decay.
  a_div_done_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> (status.command == CMD_QUERY || status.command == CMD_DECAY))
    else $error("divider finished outside query or decay");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the decaying signal grid: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import dsg_pkg::*;

  localparam int GW        = 64;
  localparam int GH        = 64;
  localparam int NKINDS    = 6;
  localparam int SHIFT     = 4;
  localparam int RAD_MAX   = 3;
  localparam int NSLOTS    = GW * GH * NKINDS;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    bit                 is_cfg;
    cfg_index_e         cfg_idx;
    logic [31:0]        cfg_data;
    cmd_e               command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [2:0]         kind;
    logic [15:0]        strength;
    logic [31:0]        tick;
    logic [1:0]         radius;
    bit                 typed;
    bit                 t_status;
    logic [15:0]        t_value;
  } grid_item_t;

  typedef struct {
    bit          typed;
    bit          status;
    logic [15:0] value;
  } grid_result_t;

  logic clk;
  logic rst_n;

  dsg_in_if  in_ch ();
  dsg_out_if out_ch ();
  dsg_cfg_if cfg_ch ();

  decaying_signal_grid u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the grid and its registers
  logic [15:0] strength_mem [NSLOTS];
  logic [31:0] stamp_mem [NSLOTS];
  int          org_x;
  int          org_y;
  logic [31:0] half_life;

  grid_result_t typed_q[$];   // per driven beat: typed-in expectation or not
  grid_result_t result_due_q[$];
  grid_item_t   dir_tab[$];

  int  beats_sent;
  int  results_seen;
  int  mismatches;
  bit  quiet;
  bit  long_hold_req;

  // Q0.32 factors 2^-(2^k/256)
  const longint unsigned halving_step [8] = '{
    64'd4283353946, 64'd4271771998, 64'd4248701966, 64'd4202935003,
    64'd4112874793, 64'd3938502376, 64'd3611622603, 64'd3037000500
  };

  function automatic longint unsigned decay_fraction(logic [7:0] idx);
    longint unsigned acc;
    acc = 64'h1_0000_0000;
    for (int k = 0; k < 8; k++) begin
      if (idx[k]) begin
        acc = (acc * halving_step[k] + 64'h8000_0000) >> 32;
      end
    end
    return (acc + 64'd32768) >> 16;
  endfunction

  function automatic bit find_cell(logic signed [15:0] px, logic signed [15:0] py,
                                   output int cx, output int cy);
    int ox;
    int oy;
    ox = int'(px) - org_x;
    oy = int'(py) - org_y;
    cx = 0;
    cy = 0;
    if (ox < 0 || oy < 0) return 1'b0;
    cx = ox >>> SHIFT;
    cy = oy >>> SHIFT;
    return (cx < GW && cy < GH);
  endfunction

  function automatic int slot_index(int cx, int cy, int kind);
    return (cy * GW + cx) * NKINDS + kind;
  endfunction

  // Age every slot of the grid to the time given, unless the half life is zero
  task automatic age_grid(logic [31:0] now);
    longint unsigned s;
    longint unsigned el;
    longint unsigned q;
    longint unsigned r;
    longint unsigned t;
    logic [7:0]      idx;
    if (half_life == 0) return;
    for (int i = 0; i < NSLOTS; i++) begin
      s = strength_mem[i];
      if (s <= EPSILON) begin
        strength_mem[i] = '0;
        continue;
      end
      if (now <= stamp_mem[i]) continue;
      el  = now - stamp_mem[i];
      q   = el / half_life;
      r   = el % half_life;
      idx = 8'((r * 256) / half_life);
      t   = (s * decay_fraction(idx) + 64'd32768) >> 16;
      t   = (q >= 32) ? 64'd0 : (t >> q);
      if (t > 65535) t = 65535;
      if (t <= EPSILON) t = 0;
      strength_mem[i] = 16'(t);
      stamp_mem[i]    = now;
    end
  endtask

  function automatic logic [15:0] neighbourhood_mean(int cx, int cy, int kind, int rad);
    longint unsigned sum;
    longint unsigned total;
    longint unsigned w;
    longint unsigned v;
    int              nx;
    int              ny;
    int              d;
    sum   = 0;
    total = 0;
    if (rad > RAD_MAX) rad = RAD_MAX;
    for (int dy = -rad; dy <= rad; dy++) begin
      for (int dx = -rad; dx <= rad; dx++) begin
        nx = cx + dx;
        ny = cy + dy;
        if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
        d     = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        w     = 360360 / (1 + d);
        sum   += longint'(strength_mem[slot_index(nx, ny, kind)]) * w;
        total += w;
      end
    end
    if (total == 0) return '0;
    v = (sum + total / 2) / total;
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // Apply one accepted beat to the shadow grid and work out its result
  task automatic grid_step(grid_item_t it, output bit st, output logic [15:0] val);
    int              cx;
    int              cy;
    int              i;
    longint unsigned s;
    longint unsigned ns;
    st  = 1'b0;
    val = '0;
    if (it.command == CMD_DECAY) begin
      age_grid(it.tick);
    end else if (it.command == CMD_RESERVED) begin
      st = 1'b1;
    end else if (it.kind >= NKINDS || !find_cell(it.pos_x, it.pos_y, cx, cy)) begin
      st = 1'b1;
    end else if (it.command == CMD_OBSERVE) begin
      i  = slot_index(cx, cy, it.kind);
      s  = strength_mem[i];
      ns = s + ((65535 - s) * it.strength + 32767) / 65535;
      if (ns > 65535) ns = 65535;
      strength_mem[i] = 16'(ns);
      stamp_mem[i]    = it.tick;
    end else begin
      val = neighbourhood_mean(cx, cy, it.kind, it.radius);
    end
  endtask

  // Input monitor: predict on every accepted beat
  always @(posedge clk) begin
    grid_item_t   it;
    grid_result_t typed;
    grid_result_t due;
    bit           st;
    logic [15:0]  val;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.command  = cmd_e'(in_ch.command);
      it.pos_x    = in_ch.pos_x;
      it.pos_y    = in_ch.pos_y;
      it.kind     = in_ch.kind;
      it.strength = in_ch.strength;
      it.tick     = in_ch.tick;
      it.radius   = in_ch.radius;
      grid_step(it, st, val);
      typed = typed_q.pop_front();
      due.typed  = typed.typed;
      due.status = typed.typed ? typed.status : st;
      due.value  = typed.typed ? typed.value : val;
      result_due_q.push_back(due);
    end
  end

  // Output monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    grid_result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (result_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d value %0d",
                   out_ch.status, out_ch.value);
      end else begin
        due = result_due_q.pop_front();
        if (out_ch.status !== due.status || out_ch.value !== due.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: status exp %0d got %0d, value exp %0d got %0d",
                     results_seen, due.status, out_ch.status, due.value, out_ch.value);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    int idle;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("FAIL decaying_signal_grid");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (2000) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end
    end
  end

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen < beats_sent) @(posedge clk);
  endtask

  // Write one register; called while the block is idle or still clearing after reset
  task automatic write_reg(cfg_index_e idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ORIGIN_X:  org_x = int'($signed(data[15:0]));
      CFG_ORIGIN_Y:  org_y = int'($signed(data[15:0]));
      CFG_HALF_LIFE: half_life = data;
      default: ;
    endcase
  endtask

  // Drive one beat and hold it until taken; then maybe drop valid for a burst
  task automatic send_beat(grid_item_t it);
    grid_result_t typed;
    typed.typed  = it.typed;
    typed.status = it.t_status;
    typed.value  = it.t_value;
    typed_q.push_back(typed);
    in_ch.valid    <= 1'b1;
    in_ch.command  <= it.command;
    in_ch.pos_x    <= it.pos_x;
    in_ch.pos_y    <= it.pos_y;
    in_ch.kind     <= it.kind;
    in_ch.strength <= it.strength;
    in_ch.tick     <= it.tick;
    in_ch.radius   <= it.radius;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic grid_item_t row(cmd_e c, int px, int py, int k, int s, logic [31:0] tk,
                                     int r, bit typed = 1'b0, bit st = 1'b0, int val = 0);
    grid_item_t it;
    it.is_cfg   = 1'b0;
    it.cfg_idx  = CFG_ORIGIN_X;
    it.cfg_data = '0;
    it.command  = c;
    it.pos_x    = 16'(px);
    it.pos_y    = 16'(py);
    it.kind     = 3'(k);
    it.strength = 16'(s);
    it.tick     = tk;
    it.radius   = 2'(r);
    it.typed    = typed;
    it.t_status = st;
    it.t_value  = 16'(val);
    return it;
  endfunction

  function automatic grid_item_t cfg_row(cfg_index_e idx, logic [31:0] data);
    grid_item_t it;
    it          = row(CMD_OBSERVE, 0, 0, 0, 0, 0, 0);
    it.is_cfg   = 1'b1;
    it.cfg_idx  = idx;
    it.cfg_data = data;
    return it;
  endfunction

  // Random positions: mostly just around the grid, sometimes anywhere
  function automatic int rand_pos(int origin);
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535));
    return origin + int'($urandom_range(0, 1100)) - 40;
  endfunction

  // Random phase: observes, queries near recent activity, at most two decays and reserved noise
  task automatic random_phase(int n_items, ref logic [31:0] now);
    grid_item_t it;
    int         hot_x[$];
    int         hot_y[$];
    int         pick;
    int         decays;
    int         sel;
    int         px;
    int         py;
    logic [31:0] tk;
    decays = 0;
    for (int n = 0; n < n_items; n++) begin
      now += $urandom_range(1, 60);
      sel = $urandom_range(0, 99);
      px  = rand_pos(org_x);
      py  = rand_pos(org_y);
      tk  = ($urandom_range(0, 9) == 0) ? 32'($urandom()) : now;
      if (sel < 4 && decays < 2) begin
        decays++;
        if ($urandom_range(0, 3) == 0) tk = $urandom_range(0, 200);
        it = row(CMD_DECAY, $urandom(), $urandom(), $urandom(), $urandom(), tk, $urandom());
      end else if (sel < 10) begin
        it = row(CMD_RESERVED, px, py, $urandom_range(0, 7), $urandom(), tk,
                 $urandom_range(0, 3));
      end else if (sel < 55) begin
        it = row(CMD_OBSERVE, px, py, $urandom_range(0, 7), $urandom_range(0, 65535), tk,
                 $urandom_range(0, 3));
        hot_x.push_back(px);
        hot_y.push_back(py);
      end else begin
        if (hot_x.size() != 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, hot_x.size() - 1);
          px   = hot_x[pick];
          py   = hot_y[pick];
        end
        it = row(CMD_QUERY, px, py, $urandom_range(0, 7), $urandom(), tk,
                 $urandom_range(0, 3));
      end
      send_beat(it);
    end
  endtask

  initial begin
    logic [31:0] now;
    rst_n        = 1'b0;
    quiet        = 1'b0;
    long_hold_req = 1'b0;
    beats_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    org_x        = 0;
    org_y        = 0;
    half_life    = '0;
    now          = 32'd2000;
    for (int i = 0; i < NSLOTS; i++) begin
      strength_mem[i] = '0;
      stamp_mem[i]    = '0;
    end
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_OBSERVE;
    in_ch.pos_x    <= '0;
    in_ch.pos_y    <= '0;
    in_ch.kind     <= '0;
    in_ch.strength <= '0;
    in_ch.tick     <= '0;
    in_ch.radius   <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_ORIGIN_X;
    cfg_ch.data    <= '0;

    // Directed table, origin at zero and decay off to begin with
    dir_tab.push_back(row(CMD_QUERY,       0,      0, 0,     0,  0, 3, 1, 0, 0));
    dir_tab.push_back(row(CMD_OBSERVE,     0,      0, 0, 65535, 10, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_QUERY,       0,      0, 0,     0,  0, 0, 1, 0, 65535));
    dir_tab.push_back(row(CMD_OBSERVE,     5,      5, 6,  1000, 11, 0, 1, 1, 0));
    dir_tab.push_back(row(CMD_QUERY,       5,      5, 7,     0,  0, 1, 1, 1, 0));
    dir_tab.push_back(row(CMD_OBSERVE,    -1,      3, 0,  1000, 12, 0, 1, 1, 0));
    dir_tab.push_back(row(CMD_QUERY,    1024,      0, 0,     0,  0, 2, 1, 1, 0));
    dir_tab.push_back(row(CMD_QUERY,    1023,   1023, 5,     0,  0, 3));
    dir_tab.push_back(row(CMD_OBSERVE,  1023,   1023, 5,     0, 32'hFFFF_FFFF, 3, 1, 0, 0));
    dir_tab.push_back(row(CMD_OBSERVE, 32767, -32768, 1, 40000, 13, 0, 1, 1, 0));
    dir_tab.push_back(row(CMD_RESERVED,    0,      0, 0, 65535, 14, 3, 1, 1, 0));
    dir_tab.push_back(row(CMD_DECAY,       0,      0, 0,     0, 1000, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_QUERY,       0,      0, 0,     0,  0, 0, 1, 0, 65535));
    dir_tab.push_back(row(CMD_OBSERVE,    17,     33, 1, 32768,  5, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_OBSERVE,    17,     33, 1, 12345,  7, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_QUERY,      17,     33, 1,     0,  0, 1));
    // Turn decay on: a near-empty slot, a slot stamped in the future, an old one
    dir_tab.push_back(cfg_row(CFG_HALF_LIFE, 32'd16));
    dir_tab.push_back(row(CMD_OBSERVE,    40,     40, 2,     5, 100, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_OBSERVE,     0,      0, 3, 40000, 5000, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_DECAY,       0,      0, 0,     0, 1000, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_QUERY,      40,     40, 2,     0,  0, 0, 1, 0, 0));
    dir_tab.push_back(row(CMD_QUERY,       0,      0, 3,     0,  0, 0));
    dir_tab.push_back(row(CMD_QUERY,       0,      0, 0,     0,  0, 3));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Registers written after reset, during the clearing pass
    write_reg(CFG_ORIGIN_X, 32'd0);
    write_reg(CFG_ORIGIN_Y, 32'd0);
    write_reg(CFG_HALF_LIFE, 32'd0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        in_ch.valid <= 1'b0;
        write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_data);
      end else begin
        send_beat(dir_tab[i]);
      end
    end

    // Lowest x origin, a negative y origin, short half life; hold the receiver off long enough to back up
    drain();
    in_ch.valid <= 1'b0;
    write_reg(CFG_ORIGIN_X, 32'hFFFF_8000);
    write_reg(CFG_ORIGIN_Y, 32'hFFFF_FC18);
    write_reg(CFG_HALF_LIFE, 32'd100);
    long_hold_req = 1'b1;
    random_phase(35, now);

    // Highest y origin, a high x origin and the longest half life
    drain();
    in_ch.valid <= 1'b0;
    write_reg(CFG_ORIGIN_X, 32'h0000_7BFF);
    write_reg(CFG_ORIGIN_Y, 32'h0000_7FFF);
    write_reg(CFG_HALF_LIFE, 32'hFFFF_FFFF);
    random_phase(30, now);

    // One-tick half life, no idling on either side to the end
    drain();
    in_ch.valid <= 1'b0;
    write_reg(CFG_ORIGIN_X, 32'hFFFF_FF38);
    write_reg(CFG_ORIGIN_Y, 32'hFFFF_8000);
    write_reg(CFG_HALF_LIFE, 32'd1);
    quiet = 1'b1;
    random_phase(35, now);

    drain();
    in_ch.valid <= 1'b0;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && result_due_q.size() == 0) begin
      $display("PASS decaying_signal_grid");
    end else begin
      $display("FAIL decaying_signal_grid");
    end
    $finish;
  end

endmodule

FILE: decaying_signal_grid.f
rtl/dsg_pkg.sv
rtl/dsg_if.sv
rtl/dsg_ram.sv
rtl/dsg_div.sv
rtl/dsg_ctrl.sv
rtl/dsg_dp.sv
rtl/decaying_signal_grid.sv
bench/tb_top.sv
